>>> sv/mpfd_pkg.sv
// ----------------------------------------------------------------------------
// mpfd_pkg
// Shared constants, types and codes of the motion, presence and fall detector.
// ----------------------------------------------------------------------------
package mpfd_pkg;

  // Phase window and the fill needed before motion energy is computed.
  localparam int WINDOW   = 20;
  localparam int MIN_FILL = 10;
  localparam int FALL_MIN = (WINDOW < 3) ? WINDOW : 3;

  // Derived widths.
  localparam int PTR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int NUM_W = $clog2(WINDOW + 1);
  localparam int IDX_W = PTR_W + 1;
  localparam int SUM_W = 32 + PTR_W;

  // Shared divider and square root widths.
  localparam int DVD_W     = 64;
  localparam int DSR_W     = 16;
  localparam int DIV_CNT_W = 7;
  localparam int SQRT_CNT_W = 6;

  // Fixed thresholds in Q16.16.
  localparam logic [31:0] DEFAULT_THRESHOLD = 32'd3277;
  localparam logic [31:0] THRESHOLD_FLOOR   = 32'd655;
  localparam logic [31:0] SIGMA_FALLBACK    = 32'd66;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_PRESENCE_THR,
    REG_FALL_THR,
    REG_CALIB_FRAMES,
    REG_SIGMA_MULT,
    REG_COOLDOWN,
    REG_MIN_CONSEC
  } cfg_reg_t;

  // Frame sequencer states.
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_PREP,
    ST_S1_RD,
    ST_S1_ACC,
    ST_DIV1_GO,
    ST_DIV1_WAIT,
    ST_S2_RD,
    ST_S2_DIF,
    ST_S2_MUL,
    ST_S2_ACC,
    ST_DIV2_GO,
    ST_DIV2_WAIT,
    ST_ENERGY,
    ST_LEARN,
    ST_L_MUL,
    ST_L_ACC,
    ST_LM_GO,
    ST_LM_WAIT,
    ST_LE_GO,
    ST_LE_WAIT,
    ST_L_VAR,
    ST_SQRT_GO,
    ST_SQRT_WAIT,
    ST_L_SMUL,
    ST_L_THR,
    ST_FALL,
    ST_OUT
  } state_t;

  // Divider request and response.
  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DSR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quotient;
    logic [DSR_W-1:0] remainder;
  } div_rsp_t;

  // Square root request and response.
  typedef struct packed {
    logic        start;
    logic [63:0] radicand;
  } sqrt_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] root;
  } sqrt_rsp_t;

endpackage

>>> sv/mpfd_ram.sv
// ----------------------------------------------------------------------------
// mpfd_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mpfd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 20
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/mpfd_div.sv
// ----------------------------------------------------------------------------
// mpfd_div
// Bit-serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mpfd_div (
  input  logic              clk,
  input  logic              rst,
  input  mpfd_pkg::div_req_t req,
  output mpfd_pkg::div_rsp_t rsp
);
  import mpfd_pkg::*;

  logic [DVD_W-1:0]     dvd;
  logic [DSR_W-1:0]     dsr;
  logic [DSR_W-1:0]     rem;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;
  logic                 done;
  logic [DSR_W:0]       rem_sh;
  logic                 fits;

  // Shift the next dividend bit into the partial remainder and trial subtract.
  assign rem_sh = {rem, dvd[DVD_W-1]};
  assign fits   = (rem_sh >= {1'b0, dsr});

  // Control: busy while the quotient bits are formed, then a one-cycle done pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(DVD_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: quotient bits replace dividend bits from the bottom.
  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd <= req.dividend;
      dsr <= req.divisor;
      rem <= '0;
    end else if (busy) begin
      dvd <= {dvd[DVD_W-2:0], fits};
      rem <= fits ? DSR_W'(rem_sh - {1'b0, dsr}) : rem_sh[DSR_W-1:0];
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = dvd;
  assign rsp.remainder = rem;

endmodule

>>> sv/mpfd_isqrt.sv
// ----------------------------------------------------------------------------
// mpfd_isqrt
// Iterative integer square root of a 64-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module mpfd_isqrt (
  input  logic                clk,
  input  logic                rst,
  input  mpfd_pkg::sqrt_req_t  req,
  output mpfd_pkg::sqrt_rsp_t  rsp
);
  import mpfd_pkg::*;

  logic [63:0]           x;
  logic [63:0]           res;
  logic [63:0]           bitv;
  logic [SQRT_CNT_W-1:0] cnt;
  logic                  busy;
  logic                  done;
  logic [63:0]           trial;

  assign trial = res + bitv;

  // Control: 32 steps, then a one-cycle done pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= SQRT_CNT_W'(32);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == SQRT_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // One digit step of the classic shift-and-subtract root.
  always_ff @(posedge clk) begin
    if (req.start) begin
      x    <= req.radicand;
      res  <= '0;
      bitv <= 64'h4000_0000_0000_0000;
    end else if (busy) begin
      if (x >= trial) begin
        x   <= x - trial;
        res <= (res >> 1) + bitv;
      end else begin
        res <= res >> 1;
      end
      bitv <= bitv >> 2;
    end
  end

  assign rsp.done = done;
  assign rsp.root = res[31:0];

endmodule

>>> sv/motion_presence_fall_detector_core.sv
// ----------------------------------------------------------------------------
// motion_presence_fall_detector_core
// Per-frame motion energy, presence and fall detection over a phase window.
// ----------------------------------------------------------------------------
//  Channel  Handshake             Payload
//  cfg      cfg_we                cfg_index, cfg_data
//  in       in_valid / in_ready   phase_sample, now_ms
//  out      out_valid / out_ready energy_level, presence, fall, calibrated,
//                                 threshold_used
//
//  A frame with n >= 10 phases in the window runs the two window passes and
//  the two divisions for mean and energy; while learning it adds the learning
//  steps, and the frame that ends learning adds two more divisions and, unless
//  the variance is zero, the root. Frames taken before the window holds 10
//  phases skip the window passes. The waits on the bit-serial divider, used
//  twice per frame, set most of the frame time.
//  Reset is synchronous; the phase store is not cleared, since only written
//  entries are read. A new beat is taken while a finished result waits on
//  the output register; a stalled output holds the sequencer at its end.
// ----------------------------------------------------------------------------
module motion_presence_fall_detector_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] phase_sample,
  input  logic [31:0]        now_ms,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [31:0]        energy_level,
  output logic               presence,
  output logic               fall,
  output logic               calibrated,
  output logic [31:0]        threshold_used
);
  import mpfd_pkg::*;

  // Configuration registers.
  logic [31:0] presence_thr;
  logic [31:0] fall_thr;
  logic [15:0] calib_frames;
  logic [15:0] sigma_mult;
  logic [31:0] cooldown;
  logic [7:0]  min_consec;

  // Frame state.
  state_t           state;
  state_t           state_next;
  logic [PTR_W-1:0] write_ptr;
  logic [NUM_W-1:0] fill_count;
  logic [31:0]      energy_reg;
  logic [31:0]      last_velocity;
  logic [7:0]       over_count;
  logic [31:0]      last_alert_ms;
  logic             fall_flag;
  logic [47:0]      calib_sum;
  logic [63:0]      calib_sq_sum;
  logic [15:0]      calib_seen;
  logic             calib_done;
  logic [31:0]      learned_thr;

  // Working registers.
  logic [31:0]      ph_reg;
  logic [31:0]      now_reg;
  logic [31:0]      last_phase;
  logic [NUM_W-1:0] n_reg;
  logic [PTR_W-1:0] start_idx;
  logic [PTR_W-1:0] idx;
  logic [NUM_W-1:0] cnt;
  logic [SUM_W-1:0] sum_s;
  logic [31:0]      mean_w;
  logic [NUM_W-1:0] rem_r;
  logic [63:0]      sq_t;
  logic             sq_sat;
  logic [31:0]      op_a;
  logic [31:0]      op_b;
  logic [63:0]      mul_p;
  logic [31:0]      mean_c;
  logic [63:0]      esq;
  logic [63:0]      var_reg;

  // Memory, divider and root unit connections.
  logic       ram_we;
  logic [31:0] ram_rdata;
  div_req_t   div_req;
  div_rsp_t   div_rsp;
  sqrt_req_t  sqrt_req;
  sqrt_rsp_t  sqrt_rsp;

  // Combinational helpers.
  logic [IDX_W-1:0]       start_raw;
  logic [PTR_W-1:0]       start_calc;
  logic [PTR_W-1:0]       idx_inc;
  logic [NUM_W-1:0]       cnt_inc;
  logic                   cnt_last;
  logic [DVD_W-1:0]       mean_dvd;
  logic signed [32:0]     dev;
  logic [32:0]            dev_abs;
  logic [64:0]            sq_add;
  logic [NUM_W+15:0]      rem_full;
  logic [2*NUM_W+15:0]    rem_prod;
  logic [2*NUM_W-1:0]     r_sq;
  logic [63:0]            q_adj;
  logic [31:0]            energy_new;
  logic                   learn_en;
  logic [64:0]            csq_add;
  logic [63:0]            var_calc;
  logic [40:0]            thr_wide;
  logic [31:0]            thr_new;
  logic [32:0]            vel_raw;
  logic [31:0]            vel;
  logic [32:0]            acc_raw;
  logic [32:0]            acc_abs;
  logic [7:0]             over_upd;
  logic                   alert;
  logic [31:0]            thr_sel;
  logic                   out_free;

  // Phase store.
  mpfd_ram #(
    .WIDTH(32),
    .DEPTH(WINDOW)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (write_ptr),
    .wdata (phase_sample),
    .raddr (idx),
    .rdata (ram_rdata)
  );

  mpfd_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  mpfd_isqrt u_sqrt (
    .clk (clk),
    .rst (rst),
    .req (sqrt_req),
    .rsp (sqrt_rsp)
  );

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      presence_thr <= 32'd0;
      fall_thr     <= 32'd32768;
      calib_frames <= 16'd100;
      sigma_mult   <= 16'd768;
      cooldown     <= 32'd5000;
      min_consec   <= 8'd3;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_PRESENCE_THR: presence_thr <= cfg_data;
        REG_FALL_THR:     fall_thr     <= cfg_data;
        REG_CALIB_FRAMES: calib_frames <= cfg_data[15:0];
        REG_SIGMA_MULT:   sigma_mult   <= cfg_data[15:0];
        REG_COOLDOWN:     cooldown     <= cfg_data;
        REG_MIN_CONSEC:   min_consec   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Window walk addressing: the oldest of the last n entries comes first.
  assign start_raw  = IDX_W'(write_ptr) + IDX_W'(WINDOW) - IDX_W'(fill_count);
  assign start_calc = (start_raw >= IDX_W'(WINDOW)) ?
                      PTR_W'(start_raw - IDX_W'(WINDOW)) : start_raw[PTR_W-1:0];
  assign idx_inc    = (idx == PTR_W'(WINDOW - 1)) ? '0 : idx + 1'b1;
  assign cnt_inc    = cnt + 1'b1;
  assign cnt_last   = (cnt_inc == n_reg);

  // Offset the window sum so that floor division runs on an unsigned value.
  assign mean_dvd = {{(DVD_W - SUM_W){sum_s[SUM_W-1]}}, sum_s}
                  + {{(32 - NUM_W){1'b0}}, n_reg, 32'd0};

  // Deviation from the floored mean and the running sum of squares.
  assign dev     = $signed({ram_rdata[31], ram_rdata}) - $signed({mean_w[31], mean_w});
  assign dev_abs = dev[32] ? 33'(-dev) : dev;
  assign sq_add  = {1'b0, sq_t} + {1'b0, mul_p};

  // Exact floor of the variance: correct the quotient by the mean's remainder.
  assign rem_full   = {div_rsp.remainder[NUM_W-1:0], sq_t[15:0]};
  assign rem_prod   = (2*NUM_W+16)'(rem_full) * (2*NUM_W+16)'(n_reg);
  assign r_sq       = (2*NUM_W)'(rem_r) * (2*NUM_W)'(rem_r);
  assign q_adj      = ((rem_prod < (2*NUM_W+16)'(r_sq)) && (div_rsp.quotient != '0)) ?
                      div_rsp.quotient - 64'd1 : div_rsp.quotient;
  assign energy_new = (sq_sat || (q_adj[63:32] != 32'd0)) ? 32'hFFFF_FFFF : q_adj[31:0];

  // Learning arithmetic.
  assign learn_en = !calib_done && (presence_thr == 32'd0);
  assign csq_add  = {1'b0, calib_sq_sum} + {1'b0, mul_p};
  assign var_calc = (esq > mul_p) ? esq - mul_p : 64'd0;
  assign thr_wide = {9'd0, mean_c} + {1'b0, mul_p[47:8]};
  assign thr_new  = (thr_wide[40:32] != 9'd0) ? 32'hFFFF_FFFF :
                    (thr_wide[31:0] < THRESHOLD_FLOOR) ? THRESHOLD_FLOOR : thr_wide[31:0];

  // Velocity, acceleration and the over-limit count.
  assign vel_raw  = {ph_reg[31], ph_reg} - {last_phase[31], last_phase};
  assign vel      = (vel_raw[32] != vel_raw[31]) ?
                    (vel_raw[32] ? 32'h8000_0000 : 32'h7FFF_FFFF) : vel_raw[31:0];
  assign acc_raw  = {vel[31], vel} - {last_velocity[31], last_velocity};
  assign acc_abs  = acc_raw[32] ? 33'(-acc_raw) : acc_raw;
  assign over_upd = (acc_abs > {1'b0, fall_thr}) ?
                    ((over_count == 8'hFF) ? over_count : over_count + 1'b1) : 8'd0;
  assign alert    = (over_upd >= min_consec) && ((now_reg - last_alert_ms) >= cooldown);

  // Presence threshold in use.
  assign thr_sel  = (presence_thr != 32'd0) ? presence_thr :
                    calib_done ? learned_thr : DEFAULT_THRESHOLD;
  assign out_free = !out_valid || out_ready;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:      if (in_valid) state_next = ST_PREP;
      ST_PREP:      state_next = (int'(fill_count) >= MIN_FILL) ? ST_S1_RD : ST_LEARN;
      ST_S1_RD:     state_next = ST_S1_ACC;
      ST_S1_ACC:    state_next = cnt_last ? ST_DIV1_GO : ST_S1_RD;
      ST_DIV1_GO:   state_next = ST_DIV1_WAIT;
      ST_DIV1_WAIT: if (div_rsp.done) state_next = ST_S2_RD;
      ST_S2_RD:     state_next = ST_S2_DIF;
      ST_S2_DIF:    state_next = ST_S2_MUL;
      ST_S2_MUL:    state_next = ST_S2_ACC;
      ST_S2_ACC:    state_next = cnt_last ? ST_DIV2_GO : ST_S2_RD;
      ST_DIV2_GO:   state_next = ST_DIV2_WAIT;
      ST_DIV2_WAIT: if (div_rsp.done) state_next = ST_ENERGY;
      ST_ENERGY:    state_next = ST_LEARN;
      ST_LEARN:     state_next = learn_en ? ST_L_MUL : ST_FALL;
      ST_L_MUL:     state_next = ST_L_ACC;
      ST_L_ACC:     state_next = (calib_seen >= calib_frames) ? ST_LM_GO : ST_FALL;
      ST_LM_GO:     state_next = ST_LM_WAIT;
      ST_LM_WAIT:   if (div_rsp.done) state_next = ST_LE_GO;
      ST_LE_GO:     state_next = ST_LE_WAIT;
      ST_LE_WAIT:   if (div_rsp.done) state_next = ST_L_VAR;
      ST_L_VAR:     state_next = (var_calc == 64'd0) ? ST_L_SMUL : ST_SQRT_GO;
      ST_SQRT_GO:   state_next = ST_SQRT_WAIT;
      ST_SQRT_WAIT: if (sqrt_rsp.done) state_next = ST_L_SMUL;
      ST_L_SMUL:    state_next = ST_L_THR;
      ST_L_THR:     state_next = ST_FALL;
      ST_FALL:      state_next = ST_OUT;
      ST_OUT:       if (out_free) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs: handshake, store write and unit requests.
  always_comb begin
    in_ready          = 1'b0;
    div_req.start     = 1'b0;
    div_req.dividend  = mean_dvd;
    div_req.divisor   = DSR_W'(n_reg);
    sqrt_req.start    = 1'b0;
    sqrt_req.radicand = var_reg;
    unique case (state)
      ST_IDLE:    in_ready = 1'b1;
      ST_DIV1_GO: div_req.start = 1'b1;
      ST_DIV2_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = {16'd0, sq_t[63:16]};
      end
      ST_LM_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = {16'd0, calib_sum};
        div_req.divisor  = calib_seen;
      end
      ST_LE_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = calib_sq_sum;
        div_req.divisor  = calib_seen;
      end
      ST_SQRT_GO: sqrt_req.start = 1'b1;
      default: ;
    endcase
  end

  assign ram_we = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Frame state updates.
  always_ff @(posedge clk) begin
    if (rst) begin
      write_ptr     <= '0;
      fill_count    <= '0;
      energy_reg    <= 32'd0;
      last_velocity <= 32'd0;
      over_count    <= 8'd0;
      last_alert_ms <= 32'd0;
      fall_flag     <= 1'b0;
      calib_sum     <= 48'd0;
      calib_sq_sum  <= 64'd0;
      calib_seen    <= 16'd0;
      calib_done    <= 1'b0;
      learned_thr   <= DEFAULT_THRESHOLD;
      out_valid     <= 1'b0;
    end else begin
      if (ram_we) begin
        write_ptr <= (write_ptr == PTR_W'(WINDOW - 1)) ? '0 : write_ptr + 1'b1;
        if (fill_count != NUM_W'(WINDOW)) begin
          fill_count <= fill_count + 1'b1;
        end
      end
      if (state == ST_ENERGY) begin
        energy_reg <= energy_new;
      end
      if (state == ST_LEARN && learn_en) begin
        calib_sum <= calib_sum + {16'd0, energy_reg};
        if (calib_seen != 16'hFFFF) begin
          calib_seen <= calib_seen + 1'b1;
        end
      end
      if (state == ST_L_ACC) begin
        calib_sq_sum <= csq_add[64] ? 64'hFFFF_FFFF_FFFF_FFFF : csq_add[63:0];
      end
      if (state == ST_L_THR) begin
        learned_thr <= thr_new;
        calib_done  <= 1'b1;
      end
      if (state == ST_FALL && int'(fill_count) >= FALL_MIN) begin
        last_velocity <= vel;
        if (alert) begin
          fall_flag     <= 1'b1;
          last_alert_ms <= now_reg;
          over_count    <= 8'd0;
        end else begin
          over_count <= over_upd;
          if (over_upd == 8'd0) begin
            fall_flag <= 1'b0;
          end
        end
      end
      if (state == ST_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Working datapath registers.
  always_ff @(posedge clk) begin
    mul_p <= 64'(op_a) * 64'(op_b);
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          ph_reg  <= phase_sample;
          now_reg <= now_ms;
        end
      end
      ST_PREP: begin
        n_reg     <= fill_count;
        start_idx <= start_calc;
        idx       <= start_calc;
        cnt       <= '0;
        sum_s     <= '0;
      end
      ST_S1_ACC: begin
        sum_s <= sum_s + {{(SUM_W - 32){ram_rdata[31]}}, ram_rdata};
        idx   <= idx_inc;
        cnt   <= cnt_inc;
      end
      ST_DIV1_WAIT: begin
        if (div_rsp.done) begin
          mean_w <= div_rsp.quotient[31:0];
          rem_r  <= div_rsp.remainder[NUM_W-1:0];
          idx    <= start_idx;
          cnt    <= '0;
          sq_t   <= 64'd0;
          sq_sat <= 1'b0;
        end
      end
      ST_S2_DIF: begin
        op_a <= dev_abs[31:0];
        op_b <= dev_abs[31:0];
        if (dev_abs[32:31] != 2'b00) begin
          sq_sat <= 1'b1;
        end
      end
      ST_S2_ACC: begin
        sq_t <= sq_add[63:0];
        if (sq_add[64]) begin
          sq_sat <= 1'b1;
        end
        idx <= idx_inc;
        cnt <= cnt_inc;
      end
      ST_LEARN: begin
        op_a <= energy_reg;
        op_b <= energy_reg;
      end
      ST_LM_WAIT: begin
        if (div_rsp.done) begin
          mean_c <= div_rsp.quotient[31:0];
          op_a   <= div_rsp.quotient[31:0];
          op_b   <= div_rsp.quotient[31:0];
        end
      end
      ST_LE_WAIT: begin
        if (div_rsp.done) begin
          esq <= div_rsp.quotient;
        end
      end
      ST_L_VAR: begin
        var_reg <= var_calc;
        op_a    <= SIGMA_FALLBACK;
        op_b    <= {16'd0, sigma_mult};
      end
      ST_SQRT_WAIT: begin
        if (sqrt_rsp.done) begin
          op_a <= sqrt_rsp.root;
          op_b <= {16'd0, sigma_mult};
        end
      end
      ST_FALL: last_phase <= ph_reg;
      ST_OUT: begin
        if (out_free) begin
          energy_level   <= energy_reg;
          presence       <= (energy_reg > thr_sel);
          fall           <= fall_flag;
          calibrated     <= calib_done;
          threshold_used <= thr_sel;
        end
      end
      default: ;
    endcase
  end

  // Checks on the sequencer and frame state.
  a_idle_holds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && !in_valid) |=> (state == ST_IDLE))
    else $error("sequencer left idle without an input beat");

  a_out_from_seq: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == ST_OUT))
    else $error("result raised outside the output step");

  a_calib_sticky: assert property (@(posedge clk) disable iff (rst)
    calib_done |=> calib_done)
    else $error("learned threshold was dropped");

  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    (write_ptr <= PTR_W'(WINDOW - 1)) && (fill_count <= NUM_W'(WINDOW)))
    else $error("write pointer or fill count out of range");

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the motion, presence and fall detector core. A queue of
// frames feeds a clocked driver; a clocked monitor compares every result beat
// with a frame predictor kept in the testbench, through several register
// settings including the extremes and the adaptive learning path.
// ----------------------------------------------------------------------------
module tb_top;
  import mpfd_pkg::*;

  typedef struct {
    logic signed [31:0] phase;
    logic [31:0]        stamp;
  } frame_t;

  typedef struct {
    logic [31:0] energy;
    logic        presence;
    logic        fall;
    logic        calibrated;
    logic [31:0] thr;
  } verdict_t;

  logic clk, rst;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [31:0] cfg_data;
  logic in_valid, in_ready;
  logic signed [31:0] phase_sample;
  logic [31:0] now_ms;
  logic out_valid, out_ready;
  logic [31:0] energy_level, threshold_used;
  logic presence, fall, calibrated;

  motion_presence_fall_detector_core DUT (.*);

  // Predictor copy of configuration and state.
  logic [31:0] p_presence_thr, p_fall_thr, p_cooldown;
  logic [15:0] p_calib_frames, p_sigma_mult;
  logic [7:0]  p_min_consec;
  longint      ring [WINDOW];
  int unsigned fill, wptr;
  logic [31:0] energy;
  longint      last_vel;
  int unsigned over_cnt;
  logic [31:0] last_alert;
  logic        fall_flag, learned;
  logic [63:0] sum_e, sumsq_e;
  int unsigned frames_seen;
  logic [31:0] learned_thr;

  frame_t   pending_frames[$];
  verdict_t expected_verdicts[$];
  int       mismatches, beats_checked, cycles;
  bit       hold_output;
  logic [31:0] clock_ms;

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic logic [63:0] int_sqrt(input logic [63:0] x);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Exact floored population variance of the newest n phases, divided by 2^16.
  function automatic logic [31:0] window_variance(input int unsigned n);
    longint s, m, r, d;
    logic [63:0] t, sq, k, q, rem;
    bit sat;
    int unsigned idx;
    s = 0; t = 0; sat = 0;
    for (int i = 0; i < n; i++) begin
      idx = (wptr + WINDOW - n + i) % WINDOW;
      s += ring[idx];
    end
    m = s / longint'(n);
    if ((s % longint'(n)) < 0) m -= 1;
    r = s - m * longint'(n);
    for (int i = 0; i < n; i++) begin
      idx = (wptr + WINDOW - n + i) % WINDOW;
      d = ring[idx] - m;
      if (d < 0) d = -d;
      if (d >= 64'sd2147483648) begin
        sat = 1;
        break;
      end
      sq = d * d;
      if (t > ~64'd0 - sq) begin
        sat = 1;
        break;
      end
      t += sq;
    end
    if (sat) return 32'hFFFF_FFFF;
    k = 64'(n) << 16;
    q = t / k;
    rem = t % k;
    if (rem * n < 64'(r * r)) q = (q != 0) ? q - 1 : 0;
    return (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
  endfunction

  // Adaptive threshold learning on one energy value.
  task automatic learn_energy(input logic [31:0] e);
    logic [63:0] sq, n, mean, esq, msq, var_q, sigma, thr;
    sq = 64'(e) * 64'(e);
    sum_e += 64'(e);
    sumsq_e = (sumsq_e > ~64'd0 - sq) ? ~64'd0 : sumsq_e + sq;
    if (frames_seen < 65535) frames_seen++;
    if (frames_seen < p_calib_frames) return;
    n = frames_seen;
    mean = sum_e / n;
    esq = sumsq_e / n;
    msq = mean * mean;
    var_q = (esq > msq) ? esq - msq : 0;
    sigma = (var_q != 0) ? int_sqrt(var_q) : 64'(SIGMA_FALLBACK);
    thr = mean + ((sigma * p_sigma_mult) >> 8);
    if (thr > 64'hFFFF_FFFF) thr = 64'hFFFF_FFFF;
    if (thr < 64'(THRESHOLD_FLOOR)) thr = 64'(THRESHOLD_FLOOR);
    learned_thr = thr[31:0];
    learned = 1;
  endtask

  task automatic predict_frame(input frame_t f);
    verdict_t v;
    int unsigned n;
    longint vel, acc;
    ring[wptr] = longint'(f.phase);
    wptr = (wptr + 1) % WINDOW;
    if (fill < WINDOW) fill++;
    n = (fill < WINDOW) ? fill : WINDOW;
    if (fill >= MIN_FILL) energy = window_variance(n);
    if (!learned && p_presence_thr == 0) learn_energy(energy);
    if (p_presence_thr != 0) v.thr = p_presence_thr;
    else if (learned) v.thr = learned_thr;
    else v.thr = DEFAULT_THRESHOLD;
    v.presence = energy > v.thr;
    if (fill >= FALL_MIN) begin
      vel = ring[(wptr + WINDOW - 1) % WINDOW] - ring[(wptr + WINDOW - 2) % WINDOW];
      if (vel > 64'sd2147483647) vel = 64'sd2147483647;
      if (vel < -64'sd2147483648) vel = -64'sd2147483648;
      acc = vel - last_vel;
      if (acc < 0) acc = -acc;
      last_vel = vel;
      if (acc > longint'({32'd0, p_fall_thr})) begin
        if (over_cnt < 255) over_cnt++;
      end else begin
        over_cnt = 0;
      end
      if (over_cnt >= p_min_consec && (f.stamp - last_alert) >= p_cooldown) begin
        fall_flag = 1;
        last_alert = f.stamp;
        over_cnt = 0;
      end else if (over_cnt == 0) begin
        fall_flag = 0;
      end
    end
    v.energy = energy;
    v.fall = fall_flag;
    v.calibrated = learned;
    expected_verdicts.push_back(v);
  endtask

  // Driver: one frame per beat with a random gap before each.
  int send_gap;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 0;
      send_gap <= $urandom_range(0, 19);
    end else if (in_valid && !in_ready) begin
      // hold the beat
    end else if (send_gap > 0) begin
      in_valid <= 0;
      send_gap <= send_gap - 1;
    end else if (pending_frames.size() > 0) begin
      frame_t f;
      f = pending_frames.pop_front();
      predict_frame(f);
      in_valid <= 1;
      phase_sample <= f.phase;
      now_ms <= f.stamp;
      send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
    end else begin
      in_valid <= 0;
    end
  end

  // Monitor: random stalls, plus a long hold when asked.
  int recv_gap;
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 0;
      recv_gap <= 0;
    end else begin
      if (out_valid && out_ready) begin
        verdict_t v;
        beats_checked++;
        if (expected_verdicts.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("result beat with nothing expected");
        end else begin
          v = expected_verdicts.pop_front();
          if (energy_level !== v.energy || presence !== v.presence || fall !== v.fall ||
              calibrated !== v.calibrated || threshold_used !== v.thr) begin
            mismatches++;
            if (mismatches <= 10)
              $display("beat %0d: exp e=%h p=%b f=%b c=%b t=%h got e=%h p=%b f=%b c=%b t=%h",
                       beats_checked, v.energy, v.presence, v.fall, v.calibrated, v.thr,
                       energy_level, presence, fall, calibrated, threshold_used);
          end
        end
      end
      if (hold_output) begin
        out_ready <= 0;
      end else if (recv_gap > 0) begin
        out_ready <= 0;
        recv_gap <= recv_gap - 1;
      end else if (!out_ready || out_valid) begin
        out_ready <= 1;
        if (out_valid) recv_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
      end
    end
  end

  // Long receiver hold counted in its own process.
  int hold_cycles;
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      if (hold_cycles == 1) hold_output <= 0;
    end
  end

  task automatic write_reg(input cfg_reg_t idx, input logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    case (idx)
      REG_PRESENCE_THR: p_presence_thr = val;
      REG_FALL_THR:     p_fall_thr = val;
      REG_CALIB_FRAMES: p_calib_frames = val[15:0];
      REG_SIGMA_MULT:   p_sigma_mult = val[15:0];
      REG_COOLDOWN:     p_cooldown = val;
      REG_MIN_CONSEC:   p_min_consec = val[7:0];
      default: ;
    endcase
  endtask

  task automatic drain_all();
    while (pending_frames.size() > 0 || expected_verdicts.size() > 0 || in_valid)
      @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic add_frame(input logic [31:0] ph, input logic [31:0] step_ms);
    frame_t f;
    clock_ms += step_ms;
    f.phase = ph;
    f.stamp = clock_ms;
    pending_frames.push_back(f);
  endtask

  // Smooth breathing-like motion with occasional sharp jerks for falls.
  task automatic add_scene(input int count, input int amp, input int jerk_pct);
    logic [31:0] ph;
    ph = $urandom;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 99) < jerk_pct)
        1'b1: ph += ($urandom_range(0, 1) ? 32'sd1 : -32'sd1) * $urandom_range(0, 1 << 20);
        default: ph += $urandom_range(0, amp) - amp / 2;
      endcase
      if ($urandom_range(0, 49) == 0) ph = $urandom;
      add_frame(ph, $urandom_range(0, 99) == 0 ? $urandom : $urandom_range(20, 3000));
    end
  endtask

  initial begin
    rst = 1;
    cfg_we = 0; cfg_index = 0; cfg_data = 0;
    in_valid = 0; phase_sample = 0; now_ms = 0; out_ready = 0;
    hold_output = 0; hold_cycles = 0; mismatches = 0; beats_checked = 0; cycles = 0;
    clock_ms = 0;
    p_presence_thr = 0; p_fall_thr = 32768; p_calib_frames = 100;
    p_sigma_mult = 768; p_cooldown = 5000; p_min_consec = 3;
    fill = 0; wptr = 0; energy = 0; last_vel = 0; over_cnt = 0; last_alert = 0;
    fall_flag = 0; learned = 0; sum_e = 0; sumsq_e = 0; frames_seen = 0;
    learned_thr = DEFAULT_THRESHOLD;
    repeat (10) @(posedge clk);
    rst <= 0;

    // Directed: short learning, field extremes, saturated variance and velocity.
    write_reg(REG_CALIB_FRAMES, 12);
    write_reg(REG_MIN_CONSEC, 1);
    write_reg(REG_COOLDOWN, 0);
    add_frame(32'h7FFF_FFFF, 0);
    add_frame(32'h8000_0000, 1);
    add_frame(32'h7FFF_FFFF, 32'hFFFF_FFFF);
    add_frame(32'h0000_0000, 5);
    add_frame(32'hFFFF_FFFF, 5);
    for (int i = 0; i < 9; i++) add_frame(i[0] ? 32'h8000_0000 : 32'h7FFF_FFFF, 50);
    for (int i = 0; i < 8; i++) add_frame(32'h0000_1000, 50);
    drain_all();

    // Fixed presence threshold, zero calibration count, extreme register values.
    write_reg(REG_PRESENCE_THR, 32'hFFFF_FFFF);
    write_reg(REG_FALL_THR, 0);
    write_reg(REG_MIN_CONSEC, 0);
    write_reg(REG_SIGMA_MULT, 16'hFFFF);
    write_reg(REG_CALIB_FRAMES, 0);
    write_reg(REG_COOLDOWN, 32'hFFFF_FFFF);
    add_scene(40, 4096, 10);
    drain_all();

    // Adaptive learning again is over, so vary the fixed thresholds.
    write_reg(REG_PRESENCE_THR, 1);
    write_reg(REG_FALL_THR, 32'hFFFF_FFFF);
    write_reg(REG_MIN_CONSEC, 255);
    write_reg(REG_SIGMA_MULT, 0);
    write_reg(REG_COOLDOWN, 100);
    add_scene(60, 65536, 20);
    // Long receiver hold while frames keep coming.
    hold_output = 1;
    hold_cycles = 4000;
    drain_all();

    // Random settings; the sender pauses between phases until all results are in.
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_PRESENCE_THR, $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 20000));
      write_reg(REG_FALL_THR, $urandom_range(0, 1 << 18));
      write_reg(REG_CALIB_FRAMES, $urandom_range(1, 40));
      write_reg(REG_SIGMA_MULT, $urandom);
      write_reg(REG_COOLDOWN, $urandom_range(0, 8000));
      write_reg(REG_MIN_CONSEC, $urandom_range(1, 5));
      add_scene(50, $urandom_range(16, 1 << 16), $urandom_range(0, 30));
      drain_all();
    end

    $display("covered %0d result beats over nine register settings, learning and falls",
             beats_checked);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
